[src/ilsr_pkg.sv]
// shared types and character codes for the inline link recognizer
package ilsr_pkg;

	localparam int OFS_W = 12;

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	// link text always begins right after the opening bracket
	localparam logic [OFS_W-1:0] LABEL_START_OFS = 12'd1;

	typedef enum logic [1:0] {
		ST_SCAN  = 2'd0,
		ST_MATCH = 2'd1,
		ST_FAIL  = 2'd2,
		ST_IDLE  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_TEXT       = 4'd1,
		PH_DEST_OPEN  = 4'd2,
		PH_DEST_KIND  = 4'd3,
		PH_DEST_ANGLE = 4'd4,
		PH_DEST_BARE  = 4'd5,
		PH_TITLE_KIND = 4'd6,
		PH_TITLE_DQ   = 4'd7,
		PH_TITLE_SQ   = 4'd8,
		PH_TITLE_PAR  = 4'd9,
		PH_CLOSE      = 4'd10
	} phase_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       begin_attempt;
		logic       last_byte;
	} feed_t;

	typedef struct packed {
		status_t          scan_status;
		logic [OFS_W-1:0] match_length;
		logic [OFS_W-1:0] label_start;
		logic [OFS_W-1:0] label_end;
		logic [OFS_W-1:0] dest_start;
		logic [OFS_W-1:0] dest_end;
		logic             has_title;
		logic [OFS_W-1:0] caption_start;
		logic [OFS_W-1:0] caption_end;
	} result_t;

endpackage

[src/ilsr_stream_if.sv]
// valid/ready stream channel carrying one payload beat
interface ilsr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[src/ilsr_in_reg.sv]
// input register stage for text byte beats
module ilsr_in_reg (
	input logic          clk,
	input logic          arst_n,
	ilsr_stream_if.sink   up,
	ilsr_stream_if.source down
);
	import ilsr_pkg::*;

	logic  valid_s1;
	feed_t data_s1;

	// load when empty or when the held beat leaves this cycle
	assign up.ready     = !valid_s1 || down.ready;
	assign down.valid   = valid_s1;
	assign down.payload = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up.valid && up.ready) begin
			valid_s1 <= 1'b1;
		end else if (down.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (up.valid && up.ready) begin
			data_s1 <= up.payload;
		end
	end

endmodule

[src/ilsr_engine.sv]
// link syntax state machine, offset tracking and result register
module ilsr_engine #(
	parameter int MAX_SPAN = 4096,
	parameter int MAX_NEST = 32
) (
	input logic          clk,
	input logic          arst_n,
	ilsr_stream_if.sink   item,
	ilsr_stream_if.source result
);
	import ilsr_pkg::*;

	localparam int PW = $clog2(MAX_SPAN);
	localparam int NW = $clog2(MAX_NEST + 1);
	localparam logic [PW-1:0] SPAN_LIM = PW'(MAX_SPAN - 2);
	localparam logic [NW-1:0] NEST_LIM = NW'(MAX_NEST);

	phase_t        phase_q, phase_d;
	logic [NW-1:0] nest_q, nest_d;
	logic [PW-1:0] pos_q, pos_d;
	logic          esc_q, esc_d;
	logic [PW-1:0] lend_q, lend_d;
	logic [PW-1:0] dstart_q, dstart_d;
	logic [PW-1:0] dend_q, dend_d;
	logic [PW-1:0] cstart_q, cstart_d;
	logic [PW-1:0] cend_q, cend_d;
	logic          title_q, title_d;

	logic          out_valid_q;
	result_t       result_q;
	result_t       res_c;
	status_t       status_c;

	logic          step;
	logic [7:0]    c;
	logic [PW-1:0] at_c;
	logic [PW-1:0] at_inc;
	logic [NW-1:0] bare_depth;
	logic          blank_c;
	logic          opener_c;
	logic          closer_c;
	logic [NW-1:0] text_dec;

	assign step         = item.valid && item.ready;
	assign item.ready   = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.payload = result_q;

	assign c          = item.payload.text_byte;
	assign at_c       = item.payload.begin_attempt ? '0 : pos_q + PW'(1);
	assign at_inc     = at_c + PW'(1);
	// the first destination byte enters the bare destination at depth zero
	assign bare_depth = (phase_q == PH_DEST_KIND) ? '0 : nest_q;
	assign blank_c    = (c <= CH_SPACE) || (c == CH_DEL);
	assign opener_c   = (c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_LPAREN);
	assign text_dec   = (nest_q != '0) ? nest_q - NW'(1) : '0;

	always_comb begin
		unique case (phase_q)
			PH_TITLE_DQ:  closer_c = (c == CH_DQUOTE);
			PH_TITLE_SQ:  closer_c = (c == CH_SQUOTE);
			PH_TITLE_PAR: closer_c = (c == CH_LPAREN) || (c == CH_RPAREN);
			default:      closer_c = 1'b0;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		nest_d   = nest_q;
		pos_d    = pos_q;
		esc_d    = esc_q;
		lend_d   = lend_q;
		dstart_d = dstart_q;
		dend_d   = dend_q;
		cstart_d = cstart_q;
		cend_d   = cend_q;
		title_d  = title_q;
		status_c = ST_SCAN;

		if (item.payload.begin_attempt) begin
			title_d = 1'b0;
			if (c != CH_LBRACK) begin
				status_c = ST_FAIL;
			end else begin
				phase_d = PH_TEXT;
				nest_d  = NW'(1);
			end
		end else if (phase_q == PH_IDLE) begin
			status_c = ST_IDLE;
		end else if (at_c > SPAN_LIM) begin
			status_c = ST_FAIL;
		end else begin
			unique case (phase_q)
				PH_TEXT: begin
					if (c == CH_LBRACK) begin
						if (nest_q >= NEST_LIM) status_c = ST_FAIL;
						else nest_d = nest_q + NW'(1);
					end else if (c == CH_RBRACK) begin
						nest_d = text_dec;
						if (text_dec == '0) begin
							lend_d   = at_c;
							dstart_d = at_c;
							phase_d  = PH_DEST_OPEN;
						end
					end
				end
				PH_DEST_OPEN: begin
					if (c != CH_LPAREN) status_c = ST_FAIL;
					else phase_d = PH_DEST_KIND;
				end
				PH_DEST_KIND, PH_DEST_BARE: begin
					if (phase_q == PH_DEST_KIND && c == CH_LT) begin
						dstart_d = at_inc;
						phase_d  = PH_DEST_ANGLE;
					end else begin
						if (phase_q == PH_DEST_KIND) dstart_d = at_c;
						nest_d  = bare_depth;
						phase_d = PH_DEST_BARE;
						if (c == CH_LPAREN) begin
							if (bare_depth >= NEST_LIM) status_c = ST_FAIL;
							else nest_d = bare_depth + NW'(1);
						end else if (c == CH_RPAREN) begin
							if (bare_depth == '0) begin
								// unbalanced paren ends destination and the link, no title
								dend_d   = at_c;
								title_d  = 1'b0;
								status_c = ST_MATCH;
							end else begin
								nest_d = bare_depth - NW'(1);
							end
						end else if (bare_depth == '0 && blank_c) begin
							dend_d  = at_c;
							phase_d = PH_TITLE_KIND;
						end
					end
				end
				PH_DEST_ANGLE: begin
					if (c == CH_LT && !esc_q) begin
						status_c = ST_FAIL;
					end else if (c == CH_GT && !esc_q) begin
						dend_d  = at_c;
						phase_d = PH_TITLE_KIND;
					end
				end
				PH_TITLE_KIND: begin
					if (opener_c) begin
						title_d  = 1'b1;
						cstart_d = at_inc;
						if (c == CH_DQUOTE) phase_d = PH_TITLE_DQ;
						else if (c == CH_SQUOTE) phase_d = PH_TITLE_SQ;
						else phase_d = PH_TITLE_PAR;
					end else begin
						// no title: the same byte must close the link
						title_d  = 1'b0;
						status_c = (c == CH_RPAREN) ? ST_MATCH : ST_FAIL;
					end
				end
				PH_TITLE_DQ, PH_TITLE_SQ, PH_TITLE_PAR: begin
					if (closer_c && !esc_q) begin
						cend_d  = at_c;
						phase_d = PH_CLOSE;
					end
				end
				PH_CLOSE: begin
					status_c = (c == CH_RPAREN) ? ST_MATCH : ST_FAIL;
				end
				default: begin
					status_c = ST_FAIL;
				end
			endcase
		end

		if (status_c == ST_SCAN && item.payload.last_byte) status_c = ST_FAIL;

		if (status_c != ST_IDLE) begin
			esc_d = (c == CH_BSLASH);
			pos_d = at_c;
		end
		if (status_c != ST_SCAN) phase_d = PH_IDLE;

		res_c = '0;
		res_c.scan_status = status_c;
		if (status_c == ST_MATCH) begin
			res_c.match_length = OFS_W'(at_inc);
			res_c.label_start  = LABEL_START_OFS;
			res_c.label_end    = OFS_W'(lend_d);
			res_c.dest_start   = OFS_W'(dstart_d);
			res_c.dest_end     = OFS_W'(dend_d);
			res_c.has_title    = title_d;
			if (title_d) begin
				res_c.caption_start = OFS_W'(cstart_d);
				res_c.caption_end   = OFS_W'(cend_d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			nest_q      <= '0;
			pos_q       <= '0;
			esc_q       <= 1'b0;
			lend_q      <= '0;
			dstart_q    <= '0;
			dend_q      <= '0;
			cstart_q    <= '0;
			cend_q      <= '0;
			title_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			nest_q      <= nest_d;
			pos_q       <= pos_d;
			esc_q       <= esc_d;
			lend_q      <= lend_d;
			dstart_q    <= dstart_d;
			dend_q      <= dend_d;
			cstart_q    <= cstart_d;
			cend_q      <= cend_d;
			title_q     <= title_d;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= res_c;
		end
	end

`ifndef ASSERT_OFF
	a_text_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TEXT) |-> (nest_q != '0))
		else $error("link text phase with zero nesting");

	a_nest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nest_q <= NEST_LIM)
		else $error("nesting above limit");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (pos_q <= SPAN_LIM))
		else $error("active attempt at offset beyond span");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && status_c != ST_SCAN) |=> (phase_q == PH_IDLE))
		else $error("attempt not retired after final status");
`endif

endmodule

[src/inline_link_syntax_recognizer_core.sv]
// top level of the streaming inline link recognizer
//
//  channel | dir | payload                                   | beat meaning
//  --------+-----+-------------------------------------------+-----------------------------
//  feed    | in  | text_byte, begin_attempt, last_byte       | one text byte
//  report  | out | scan_status, match_length, label/dest/    | status of that byte, plus
//          |     | caption bounds, has_title                 | link offsets on a match
//
// one text byte per cycle unless report stalls; every feed beat yields exactly one report beat
// a beat passes the feed register, then the phase logic into the report register
// the loop that sets the rate is the phase/nesting/offset state update, one step per byte
// arst_n clears the phase to idle, nesting, position and both valid flags
// a stalled report holds its beat and backpressure reaches feed in the same cycle
module inline_link_syntax_recognizer_core #(
	parameter int MAX_SPAN = 4096,
	parameter int MAX_NEST = 32
) (
	input logic          clk,
	input logic          arst_n,
	ilsr_stream_if.sink   feed,
	ilsr_stream_if.source report
);
	import ilsr_pkg::*;

	// registered feed beat handed to the phase logic
	ilsr_stream_if #(.payload_t(feed_t)) stage_link ();

	ilsr_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (feed),
		.down   (stage_link)
	);

	// phase machine, offset registers and the report register
	ilsr_engine #(
		.MAX_SPAN (MAX_SPAN),
		.MAX_NEST (MAX_NEST)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (stage_link),
		.result (report)
	);

endmodule
